// ----- rtl/utf_pkg.sv -----
package utf_pkg;

  localparam int DATA_W      = 8;
  localparam int TIME_W      = 20;
  localparam int PERIOD_W    = 16;
  localparam int BITPOS_W    = 4;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int FIFO_DEPTH_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TIME = 1'd1;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;
  localparam logic [PERIOD_W-1:0] GUARD_TIME_RST = 16'd50;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [BITPOS_W-1:0] POS_LAST_DATA = 4'd8;
  localparam logic [BITPOS_W-1:0] POS_STOP      = 4'd9;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] head;
  } utf_fifo_stat_t;

  typedef struct packed {
    logic pop;
    logic line;
    logic busy;
  } utf_ser_out_t;

endpackage

// ----- rtl/utf_ram.sv -----
module utf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/utf_fifo.sv -----
module utf_fifo import utf_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [DATA_W-1:0]                push_data,
  input  logic                             pop,
  output utf_fifo_stat_t                   stat,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]  count_nxt
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(FIFO_DEPTH);

  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic              lww_r, lww_nxt;
  logic              fwd_v_r, fwd_v_nxt;
  logic [DATA_W-1:0] fwd_d_r;
  logic [DATA_W-1:0] rdata;
  logic [CW-1:0]     count_cur;
  logic              wr_en;

  function automatic logic [CW-1:0] occupancy(input logic [AW-1:0] wp,
                                              input logic [AW-1:0] rp,
                                              input logic          lw);
    logic [CW-1:0] used;
    if (wp >= rp) begin
      used = CW'(wp - rp);
    end else begin
      used = DEPTH_C - CW'(rp - wp);
    end
    if (used == '0 && lw) begin
      used = DEPTH_C;
    end
    return used;
  endfunction

  assign count_cur  = occupancy(wr_ptr_r, rd_ptr_r, lww_r);
  assign stat.full  = (count_cur == DEPTH_C);
  assign stat.empty = (count_cur == '0);
  assign stat.head  = fwd_v_r ? fwd_d_r : rdata;
  assign wr_en      = push && !stat.full;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    lww_nxt    = lww_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      lww_nxt    = 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      lww_nxt    = 1'b0;
    end
    if (!rst_n) begin
      rd_ptr_nxt = '0;
    end
  end

  assign count_nxt = occupancy(wr_ptr_nxt, rd_ptr_nxt, lww_nxt);

  // write to the entry being fetched this cycle: RAM returns old data
  assign fwd_v_nxt = wr_en && (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      lww_r    <= 1'b0;
      fwd_v_r  <= 1'b0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      lww_r    <= lww_nxt;
      fwd_v_r  <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r <= push_data;
  end

  utf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr_r),
    .wdata (push_data),
    .raddr (rd_ptr_nxt),
    .rdata (rdata)
  );

endmodule

// ----- rtl/utf_ser.sv -----
module utf_ser import utf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic [TIME_W-1:0]   time_left,
  input  logic [PERIOD_W-1:0] bit_period,
  input  logic [PERIOD_W-1:0] guard_time,
  input  utf_fifo_stat_t      fstat,
  output utf_ser_out_t        sout
);

  logic [DATA_W-1:0]   shift_r, shift_nxt;
  logic [BITPOS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [PERIOD_W-1:0] pcnt_r, pcnt_nxt;
  logic                active_r, active_nxt;
  logic                line_r, line_nxt;
  logic [PERIOD_W-1:0] eff;
  logic [PERIOD_W:0]   pcnt_inc;
  logic [TIME_W-1:0]   need;
  logic                start;

  assign eff      = (bit_period == '0) ? PERIOD_W'(1) : bit_period;
  assign need     = TIME_W'({eff, 3'b000}) + TIME_W'({eff, 1'b0}) + TIME_W'(guard_time);
  assign pcnt_inc = {1'b0, pcnt_r} + 1'b1;
  assign pos_inc  = pos_r + 1'b1;

  always_comb begin
    shift_nxt  = shift_r;
    pos_nxt    = pos_r;
    pcnt_nxt   = pcnt_r;
    active_nxt = active_r;
    line_nxt   = line_r;
    start      = 1'b0;
    if (tick) begin
      if (active_r) begin
        if (pcnt_inc < {1'b0, eff}) begin
          pcnt_nxt = pcnt_inc[PERIOD_W-1:0];
        end else begin
          pcnt_nxt = '0;
          pos_nxt  = pos_inc;
          if (pos_inc <= POS_LAST_DATA) begin
            line_nxt = shift_r[3'(pos_inc - 1'b1)];
          end else if (pos_inc == POS_STOP) begin
            line_nxt = 1'b1;
          end else begin
            active_nxt = 1'b0;
            pos_nxt    = '0;
            line_nxt   = 1'b1;
          end
        end
      end
      if (!active_nxt && !fstat.empty && time_left >= need) begin
        start      = 1'b1;
        shift_nxt  = fstat.head;
        active_nxt = 1'b1;
        pos_nxt    = '0;
        pcnt_nxt   = '0;
        line_nxt   = 1'b0;
      end
    end
  end

  assign sout.pop  = start;
  assign sout.line = line_nxt;
  assign sout.busy = active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      pos_r    <= '0;
      pcnt_r   <= '0;
      active_r <= 1'b0;
      line_r   <= 1'b1;
    end else begin
      shift_r  <= shift_nxt;
      pos_r    <= pos_nxt;
      pcnt_r   <= pcnt_nxt;
      active_r <= active_nxt;
      line_r   <= line_nxt;
    end
  end

endmodule

// ----- rtl/uart_tx_fifo_windowed.sv -----
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_mode, in_data_byte, in_time_left
// out_    | output    | out_valid/out_stall| out_serial_out, out_accepted,
//         |           |                    | out_queue_count, out_busy_res
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_stall is low; its result is captured in the output register when the item is taken.
// Rate is set by the FIFO RAM: one write and one head prefetch per cycle.
// Synchronous reset; no clearing pass, the FIFO RAM is left as is.
// in_stall is high only while a held result is stalled at the output.
module uart_tx_fifo_windowed import utf_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  logic [DATA_W-1:0]      in_data_byte,
  input  logic [TIME_W-1:0]      in_time_left,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_serial_out,
  output logic                   out_accepted,
  output logic [COUNT_OUT_W-1:0] out_queue_count,
  output logic                   out_busy_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PERIOD_W-1:0]    cfg_data
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [PERIOD_W-1:0]    bit_period_r;
  logic [PERIOD_W-1:0]    guard_time_r;
  logic                   out_valid_r;
  logic                   serial_r, accepted_r, busy_r;
  logic [COUNT_OUT_W-1:0] qcount_r;
  logic                   take, push, tick;
  utf_fifo_stat_t         fstat;
  utf_ser_out_t           sout;
  logic [CW-1:0]          count_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign push      = take && (in_mode == MODE_WRITE);
  assign tick      = take && (in_mode == MODE_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
      guard_time_r <= GUARD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIT_PERIOD: bit_period_r <= cfg_data;
        CFG_GUARD_TIME: guard_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  utf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_data_byte),
    .pop       (sout.pop),
    .stat      (fstat),
    .count_nxt (count_nxt)
  );

  utf_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .time_left  (in_time_left),
    .bit_period (bit_period_r),
    .guard_time (guard_time_r),
    .fstat      (fstat),
    .sout       (sout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      serial_r   <= sout.line;
      accepted_r <= push && !fstat.full;
      qcount_r   <= COUNT_OUT_W'(count_nxt);
      busy_r     <= sout.busy;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_serial_out  = serial_r;
  assign out_accepted    = accepted_r;
  assign out_queue_count = qcount_r;
  assign out_busy_res    = busy_r;

`ifndef SYNTHESIS
  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_res || out_serial_out))
    else $error("line low with no frame in flight");

  a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> ((FIFO_DEPTH > 127) || (out_queue_count != '0)))
    else $error("stored byte but queue reads empty");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(fstat.full && fstat.empty))
    else $error("FIFO full and empty together");

  a_pop_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    sout.pop |-> (tick && !fstat.empty))
    else $error("dequeue without a tick or from an empty FIFO");
`endif

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import utf_pkg::*;

  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam int FRAME_BITS = 10;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_REPORTS = 10;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic                   line_lvl;
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] queued;
    logic                   busy;
  } tx_status_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_mode = MODE_WRITE;
  logic [DATA_W-1:0]      in_data_byte = '0;
  logic [TIME_W-1:0]      in_time_left = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_serial_out;
  logic                   out_accepted;
  logic [COUNT_OUT_W-1:0] out_queue_count;
  logic                   out_busy_res;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_BIT_PERIOD;
  logic [PERIOD_W-1:0]    cfg_data = '0;

  // predicted transmitter state
  logic [DATA_W-1:0]   fifo_mem [DEPTH];
  int                  rd_ptr = 0;
  int                  wr_ptr = 0;
  bit                  wrote_last = 1'b0;
  logic [DATA_W-1:0]   shift_byte = '0;
  int                  bit_pos = 0;
  int                  tick_cnt = 0;
  bit                  in_frame = 1'b0;
  logic                line_lvl = 1'b1;
  logic [PERIOD_W-1:0] period_reg = BIT_PERIOD_RST;
  logic [PERIOD_W-1:0] guard_reg = GUARD_TIME_RST;

  tx_status_t pending_status_q [$];

  int items_sent = 0;
  int writes_dropped = 0;
  int frames_started = 0;
  int results_seen = 0;
  int mismatches = 0;
  bit idle_en = 1'b1;
  bit hold_go = 1'b0;

  uart_tx_fifo_windowed dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_200_000;
    $display("Timed out with %0d results outstanding", pending_status_q.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic int fifo_used();
    int used;
    used = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    if (used == 0 && wrote_last) used = DEPTH;
    return used;
  endfunction

  function automatic int ticks_per_bit();
    return (period_reg == '0) ? 1 : int'(period_reg);
  endfunction

  function automatic int window_needed();
    return FRAME_BITS * ticks_per_bit() + int'(guard_reg);
  endfunction

  function automatic logic [TIME_W-1:0] pick_window();
    int need;
    int r;
    need = window_needed();
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 18) return TIME_W'(need - 1);
    if (r < 26) return TIME_W'(need);
    if (r < 32) return TIME_W'($urandom);
    return TIME_W'($urandom_range(int'(TIME_MAX), need));
  endfunction

  task automatic apply_item(input logic m, input logic [DATA_W-1:0] b,
                            input logic [TIME_W-1:0] t);
    tx_status_t st;
    st.accepted = 1'b0;
    if (m == MODE_WRITE) begin
      if (fifo_used() < DEPTH) begin
        fifo_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        wrote_last = 1'b1;
        st.accepted = 1'b1;
      end else begin
        writes_dropped++;
      end
    end else begin
      if (in_frame) begin
        tick_cnt++;
        if (tick_cnt >= ticks_per_bit()) begin
          tick_cnt = 0;
          bit_pos++;
          if (bit_pos <= POS_LAST_DATA) begin
            line_lvl = shift_byte[bit_pos-1];
          end else if (bit_pos == POS_STOP) begin
            line_lvl = 1'b1;
          end else begin
            in_frame = 1'b0;
            bit_pos = 0;
            line_lvl = 1'b1;
          end
        end
      end
      if (!in_frame && fifo_used() != 0 && int'(t) >= window_needed()) begin
        shift_byte = fifo_mem[rd_ptr];
        rd_ptr = (rd_ptr + 1) % DEPTH;
        wrote_last = 1'b0;
        in_frame = 1'b1;
        bit_pos = 0;
        tick_cnt = 0;
        line_lvl = 1'b0;
        frames_started++;
      end
    end
    st.line_lvl = line_lvl;
    st.queued = COUNT_OUT_W'(fifo_used());
    st.busy = in_frame;
    pending_status_q.push_back(st);
  endtask

  task automatic send_item(input logic m, input logic [DATA_W-1:0] b,
                           input logic [TIME_W-1:0] t);
    while (idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_data_byte <= b;
    in_time_left <= t;
    do @(posedge clk); while (in_stall);
    apply_item(m, b, t);
    items_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // closed window: the frame in flight completes, nothing new starts
  task automatic finish_frame();
    while (in_frame) send_item(MODE_TICK, DATA_W'($urandom), '0);
    quiesce();
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] period,
                            input logic [PERIOD_W-1:0] guard);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BIT_PERIOD;
    cfg_data <= period;
    do @(posedge clk); while (!cfg_ready);
    period_reg = period;
    cfg_index <= CFG_GUARD_TIME;
    cfg_data <= guard;
    do @(posedge clk); while (!cfg_ready);
    guard_reg = guard;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n, input int write_pct);
    repeat (n) begin
      if ($urandom_range(99) < write_pct)
        send_item(MODE_WRITE, DATA_W'($urandom), TIME_W'($urandom));
      else
        send_item(MODE_TICK, DATA_W'($urandom), pick_window());
    end
    finish_frame();
  endtask

  task automatic test_reset_defaults();
    send_item(MODE_TICK, 8'h00, '0);
    send_item(MODE_WRITE, 8'h00, TIME_MAX);
    send_item(MODE_WRITE, 8'hFF, '0);
    send_item(MODE_WRITE, 8'hA5, TIME_MAX);
    send_item(MODE_TICK, 8'hFF, TIME_W'(window_needed() - 1));
    send_item(MODE_TICK, 8'h00, TIME_W'(window_needed()));
    quiesce();
    // shorten the bit while the first bit count is still zero
    set_config(16'd1, GUARD_TIME_RST);
    repeat (12) send_item(MODE_TICK, 8'h00, TIME_MAX);
    finish_frame();
  endtask

  task automatic test_zero_period();
    set_config('0, '0);
    send_item(MODE_TICK, 8'h00, TIME_W'(window_needed() - 1));
    send_item(MODE_TICK, 8'h00, TIME_W'(window_needed()));
    send_item(MODE_WRITE, 8'h5A, TIME_MAX);
    repeat (12) send_item(MODE_TICK, 8'hFF, TIME_MAX);
    finish_frame();
  endtask

  task automatic test_extreme_period();
    set_config('1, '1);
    send_item(MODE_WRITE, 8'hC3, '0);
    send_item(MODE_TICK, 8'h00, TIME_W'(window_needed() - 1));
    send_item(MODE_TICK, 8'h00, TIME_W'(window_needed()));
    quiesce();
    set_config(16'd1, '0);
    finish_frame();
  endtask

  task automatic test_fifo_full();
    set_config('0, '0);
    repeat (DEPTH + 2) send_item(MODE_WRITE, DATA_W'($urandom), TIME_W'($urandom));
    while (fifo_used() != 0 || in_frame)
      send_item(MODE_TICK, DATA_W'($urandom), pick_window());
    quiesce();
  endtask

  task automatic test_output_hold();
    set_config(16'd2, 16'd3);
    hold_go = 1'b1;
    run_traffic(40, 50);
  endtask

  task automatic test_random();
    set_config(16'd1, '0);
    run_traffic(40, 30);
    idle_en = 1'b0;
    set_config(16'd2, 16'd7);
    run_traffic(40, 25);
    idle_en = 1'b1;
    set_config(16'd3, '1);
    run_traffic(30, 20);
    repeat (3) begin
      set_config(PERIOD_W'($urandom_range(4)), PERIOD_W'($urandom_range(200)));
      run_traffic(20, 40);
    end
  endtask

  initial begin : result_receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < 30);
      end
    end
  end

  initial begin : result_checker
    tx_status_t got;
    tx_status_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_serial_out, out_accepted, out_queue_count, out_busy_res};
        results_seen++;
        if (pending_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: transfer with no result pending: %p", $realtime, got);
        end else begin
          want = pending_status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: result %0d expected line=%b acc=%b count=%0d busy=%b",
                       $realtime, results_seen, want.line_lvl, want.accepted,
                       want.queued, want.busy);
              $display("%0t: result %0d got      line=%b acc=%b count=%0d busy=%b",
                       $realtime, results_seen, got.line_lvl, got.accepted,
                       got.queued, got.busy);
            end
          end
        end
      end
    end
  end

  initial begin : test_sequence
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_period();
    test_extreme_period();
    test_fifo_full();
    test_output_hold();
    test_random();
    quiesce();
    if (pending_status_q.size() != 0) mismatches++;
    $display("%0d items sent, %0d writes refused when full, %0d frames started, %0d checked",
             items_sent, writes_dropped, frames_started, results_seen);
    $display("Bit periods 0..65535, guard 0..65535, window edges, long output hold; %0d bad",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
